// ----- hdl/sha256_pkg.sv -----
`timescale 1ns / 1ps
package sha256_pkg;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       final_item;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_end;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic take_byte;   // absorb the accepted byte
        logic pad_start;   // write 0x80 and zero the tail words
        logic pad_length;  // write the length words into 14 and 15
        logic pad_clear;   // clear words 0..13 for a second pad block
        logic load_vars;   // copy hash into working variables
        logic round_en;    // one round
        logic add_hash;    // fold working variables into hash
        logic reset_hash;  // back to initial vector, zero count
    } t_cmd;

    typedef struct packed {
        logic       block_full;   // last absorbed byte filled the block
        logic       pad_two;      // padding needs a second block
        logic       last_round;
    } t_stat;

    localparam int RoundCount = 64;

    localparam logic [31:0] K_TABLE [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [5:0] PadLimit = 6'd56;
    localparam logic [7:0] PadByte  = 8'h80;

endpackage

// ----- hdl/sha256_datapath.sv -----
`timescale 1ns / 1ps
module sha256_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_byte,
    input  sha256_pkg::t_cmd     i_cmd,
    input  logic [2:0]           i_word_sel,
    output sha256_pkg::t_stat    o_stat,
    output logic [31:0]          o_hash_word
);

    logic [31:0] r_hash [0:7];
    logic [31:0] r_blk  [0:15];
    logic [31:0] r_v    [0:7];
    logic [31:0] r_w    [0:15];
    logic [60:0] r_count;
    logic [5:0]  r_round;

    logic [5:0]  w_off;
    logic [3:0]  w_idx;
    logic [4:0]  w_sh;
    logic [31:0] w_sched, w_s0, w_s1, w_e1, w_a0, w_ch, w_mj, w_t1, w_t2, w_x15, w_x2;
    logic [31:0] w_bytew;
    logic [63:0] w_bits;

    assign w_off  = r_count[5:0];
    assign w_idx  = w_off[5:2];
    assign w_sh   = 5'(5'd24 - {w_off[1:0], 3'b000});
    assign w_bytew = {24'd0, i_byte} << w_sh;
    assign w_bits = {r_count, 3'b000};

    // schedule ring shifts: entry 0 is w[t-16]
    assign w_x15  = r_w[1];
    assign w_x2   = r_w[14];
    assign w_s0   = {w_x15[6:0], w_x15[31:7]} ^ {w_x15[17:0], w_x15[31:18]} ^ (w_x15 >> 3);
    assign w_s1   = {w_x2[16:0], w_x2[31:17]} ^ {w_x2[18:0], w_x2[31:19]} ^ (w_x2 >> 10);
    assign w_sched = (r_round < 6'd16) ? r_blk[r_round[3:0]]
                                       : r_w[0] + w_s0 + r_w[9] + w_s1;

    assign w_e1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
                ^ {r_v[4][24:0], r_v[4][31:25]};
    assign w_ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_t1 = r_v[7] + w_e1 + w_ch + sha256_pkg::K_TABLE[r_round] + w_sched;
    assign w_a0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
                ^ {r_v[0][21:0], r_v[0][31:22]};
    assign w_mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t2 = w_a0 + w_mj;

    assign o_stat.block_full = (w_off == 6'd0);
    assign o_stat.pad_two    = (w_off >= sha256_pkg::PadLimit);
    assign o_stat.last_round = (r_round == 6'(sha256_pkg::RoundCount - 1));
    assign o_hash_word       = r_hash[i_word_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_round <= '0;
            for (int j = 0; j < 8; j++) r_hash[j] <= sha256_pkg::H_INIT[j];
        end else begin
            if (i_cmd.take_byte) begin
                r_count <= r_count + 61'd1;
                if (w_off[1:0] == 2'd0) r_blk[w_idx] <= w_bytew;
                else                    r_blk[w_idx] <= r_blk[w_idx] | w_bytew;
            end
            if (i_cmd.pad_start) begin
                for (int j = 0; j < 16; j++) begin
                    if (4'(j) > w_idx) r_blk[j] <= '0;
                end
                case (w_off[1:0])
                    2'd0:    r_blk[w_idx] <= 32'h8000_0000;
                    2'd1:    r_blk[w_idx] <= {r_blk[w_idx][31:24], 24'h80_0000};
                    2'd2:    r_blk[w_idx] <= {r_blk[w_idx][31:16], 16'h8000};
                    default: r_blk[w_idx] <= {r_blk[w_idx][31:8], sha256_pkg::PadByte};
                endcase
            end
            if (i_cmd.pad_clear) begin
                for (int j = 0; j < 14; j++) r_blk[j] <= '0;
            end
            if (i_cmd.pad_length) begin
                r_blk[14] <= w_bits[63:32];
                r_blk[15] <= w_bits[31:0];
            end
            if (i_cmd.load_vars) begin
                r_round <= '0;
                for (int j = 0; j < 8; j++) r_v[j] <= r_hash[j];
            end
            if (i_cmd.round_en) begin
                r_round <= r_round + 6'd1;
                for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
                r_w[15] <= w_sched;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + w_t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= w_t1 + w_t2;
            end
            if (i_cmd.add_hash) begin
                for (int j = 0; j < 8; j++) r_hash[j] <= r_hash[j] + r_v[j];
            end
            if (i_cmd.reset_hash) begin
                r_count <= '0;
                for (int j = 0; j < 8; j++) r_hash[j] <= sha256_pkg::H_INIT[j];
            end
        end
    end

endmodule

// ----- hdl/sha256_control.sv -----
`timescale 1ns / 1ps
module sha256_control (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sha256_pkg::t_in_item  i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_word_sel,
    input  sha256_pkg::t_stat     i_stat,
    output sha256_pkg::t_cmd      o_cmd
);

    sha256_pkg::t_state r_state, n_state;
    logic r_final;     // final item taken; held until the digest is emitted
    logic r_padded;    // the block in flight is the last one
    logic r_data;      // the block in flight holds message bytes only
    logic [2:0] r_word;
    logic w_acc;
    logic w_data_blk;

    assign o_in_stall  = (r_state != sha256_pkg::ST_IDLE);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == sha256_pkg::ST_EMIT);
    assign o_word_sel  = r_word;
    // a byte just filled the block: compress it before any padding goes in
    assign w_data_blk  = r_data && i_stat.block_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_item.byte_present && i_stat.block_full && r_final == 1'b0
                        && 1'b0) n_state = sha256_pkg::ST_IDLE;
                    else if (i_in_item.byte_present || i_in_item.final_item)
                        n_state = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD: begin
                // count already updated; decide whether a block compresses now
                if (r_final) n_state = sha256_pkg::ST_ROUND;
                else if (i_stat.block_full) n_state = sha256_pkg::ST_ROUND;
                else n_state = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_ROUND: begin
                if (i_stat.last_round) n_state = sha256_pkg::ST_ADD;
            end
            sha256_pkg::ST_ADD: begin
                if (r_padded) n_state = sha256_pkg::ST_EMIT;
                else if (r_final) n_state = sha256_pkg::ST_PAD;
                else n_state = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_EMIT: begin
                if (!i_out_stall && r_word == 3'd7) n_state = sha256_pkg::ST_IDLE;
            end
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_cmd.take_byte = w_acc && i_in_item.byte_present;
            end
            sha256_pkg::ST_PAD: begin
                o_cmd.load_vars = r_final || i_stat.block_full;
                if (r_final && !w_data_blk) begin
                    if (r_padded) begin
                        // second pad block after a full first one
                        o_cmd.pad_clear  = 1'b1;
                        o_cmd.pad_length = 1'b1;
                    end else begin
                        o_cmd.pad_start  = 1'b1;
                        o_cmd.pad_length = !i_stat.pad_two;
                    end
                end
            end
            sha256_pkg::ST_ROUND: o_cmd.round_en = 1'b1;
            sha256_pkg::ST_ADD:   o_cmd.add_hash = 1'b1;
            sha256_pkg::ST_EMIT:  o_cmd.reset_hash = !i_out_stall && r_word == 3'd7;
            default: o_cmd = '0;
        endcase
    end

    // r_padded marks the length block; set at its pad step or at the add step before it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha256_pkg::ST_IDLE;
            r_final  <= 1'b0;
            r_padded <= 1'b0;
            r_data   <= 1'b0;
            r_word   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == sha256_pkg::ST_IDLE && w_acc) begin
                r_final  <= i_in_item.final_item;
                r_padded <= 1'b0;
                r_data   <= i_in_item.byte_present;
            end
            if (r_state == sha256_pkg::ST_PAD) begin
                r_data <= w_data_blk;
                if (r_final && !w_data_blk) r_padded <= r_padded || !i_stat.pad_two;
            end
            if (r_state == sha256_pkg::ST_ADD) begin
                r_data <= 1'b0;
                if (!r_padded && r_final && !r_data) r_padded <= 1'b1;
            end
            if (r_state == sha256_pkg::ST_EMIT && !i_out_stall) begin
                r_word <= r_word + 3'd1;
                if (r_word == 3'd7) r_final <= 1'b0;
            end
        end
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::ST_ROUND) |-> o_in_stall)
        else $error("input taken during rounds");
    a_emit_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_final && r_padded)
        else $error("digest without final item");
    a_word_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> r_word == 3'd0)
        else $error("digest cut short");

endmodule

// ----- hdl/sha256_message_hasher_unit.sv -----
`timescale 1ns / 1ps
// a byte that does not complete a block passes the intake and pad steps; a block-ending byte
// adds the 64 rounds and the hash update, run one round at a time in the single round unit
// a final item adds one or two such compressions, then 8 digest words
// one per cycle when the output is not stalled
// reset (i_rst_n low, synchronous) loads the initial vector and zeroes the byte count
module sha256_message_hasher_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sha256_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sha256_pkg::t_out_item o_out_item
);

    sha256_pkg::t_cmd  w_cmd;
    sha256_pkg::t_stat w_stat;
    logic [2:0]  w_word_sel;
    logic [31:0] w_hash_word;

    // sequencer: byte intake, padding steps, round count and digest walk
    sha256_control u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_word_sel  (w_word_sel),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // block buffer, schedule ring, round unit and hash state
    sha256_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_in_item.message_byte),
        .i_cmd       (w_cmd),
        .i_word_sel  (w_word_sel),
        .o_stat      (w_stat),
        .o_hash_word (w_hash_word)
    );

    // the digest word is read straight from the hash registers, which hold still while stalled
    assign o_out_item.digest_word = w_hash_word;
    assign o_out_item.word_index  = w_word_sel;
    assign o_out_item.digest_end  = (w_word_sel == 3'd7);

endmodule
